FILE: rtl/g5ds_pkg.sv
// ----------------------------------------------------------------------------
// g5ds_pkg
// Shared types, constants and kernel table for the 5x5 Gaussian
// downsample-by-four block.
// ----------------------------------------------------------------------------
package g5ds_pkg;

    localparam int PIX_W         = 16;
    localparam int WIDTH_REG_W   = 13;
    localparam int HEIGHT_REG_W  = 15;
    localparam int CFG_DATA_W    = 15;
    localparam int CFG_IDX_W     = 1;
    localparam int ROW_W         = 14;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 16384;
    localparam int KSIZE         = 5;
    localparam int STORE_ROWS    = 4;
    localparam int SLOT_W        = 2;
    localparam int PSUM_W        = 22;
    localparam int SUM_W         = 24;

    // floor(x / 159) == (x * ceil(2^31 / 159)) >> 31 for every x below 2^24
    localparam int                RECIP_SHIFT = 31;
    localparam logic [SUM_W-1:0]  RECIP_MUL   = 24'd13506187;

    localparam int OUT_FIFO_DEPTH = 8;
    localparam int PIPE_STAGES    = 5;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 15'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]        pix_t;
    typedef pix_t [KSIZE-1:0]        pix_col_t;
    typedef pix_t [STORE_ROWS-1:0]   store_col_t;
    typedef logic [3:0]              coef_t;

    // kernel indexed [row][column]
    localparam coef_t KERN [KSIZE][KSIZE] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             row_end;
        logic             frame_end;
    } out_item_t;

    typedef struct packed {
        logic emit;
        logic vclamp;
        logic hclamp;
        logic row_end;
        logic frame_end;
    } item_ctrl_t;

    typedef struct packed {
        logic shift;
        logic use_alt;
        logic vclamp;
    } cell_ctrl_t;

endpackage

FILE: rtl/gauss_5x5_downsample_by_four_top.sv
// ----------------------------------------------------------------------------
// gauss_5x5_downsample_by_four_top
// 5x5 Gaussian filter with downsampling by four in both directions.
// ----------------------------------------------------------------------------
// Takes one 16-bit pixel per clock in raster order while s_ready is high and,
// for every pixel at column 4x+2 of row 4y+2, produces the kernel-weighted 5x5
// sum around (4x,4y) divided by 159, with rows and columns above or left of the
// frame repeating row or column zero. Four row-store banks are read and written
// in the same cycle, and the 5x5 window is a chain of five column cells that
// shifts once per accepted pixel, so a pixel can be accepted every cycle while
// s_ready is high; a result passes stages s1 to s5 into the 8-entry output
// queue and can leave on the cycle after it is written. s_ready falls only when
// queued plus in-flight results would fill that queue. The user writes frame
// size registers on the cfg port between frames; the block does not enforce it.
// ----------------------------------------------------------------------------
module gauss_5x5_downsample_by_four_top
    import g5ds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int MAXW4 = (MAX_WIDTH / 4) * 4;
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int INF_W = $clog2(PIPE_STAGES + 1);
    localparam int USE_W = CNT_W + 1;

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [WIDTH_REG_W-1:0]  width_next;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [HEIGHT_REG_W-1:0] height_next;
    logic [EW-1:0]           w_raw;
    logic [EW-1:0]           w_sat;
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_raw;
    logic [HEIGHT_REG_W-1:0] h_eff;

    // position
    logic [AW-1:0]           col_reg;
    logic [AW-1:0]           col_next;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic [AW-1:0]           c0;
    logic [ROW_W-1:0]        r0;
    logic [WW-1:0]           c_ext;
    logic [WW-1:0]           c_inc;
    logic [HEIGHT_REG_W-1:0] r_ext;
    logic [HEIGHT_REG_W-1:0] r_inc;
    logic                    wrap_col;
    logic                    wrap_row;
    logic                    accept;
    item_ctrl_t              ctrl_in;

    // pipeline
    logic                    s1_acc_reg;
    item_ctrl_t              s1_ctrl_reg;
    item_ctrl_t              s1_ctrl_next;
    pix_t                    s1_pix_reg;
    item_ctrl_t              s2_ctrl_reg;
    item_ctrl_t              s3_ctrl_reg;
    item_ctrl_t              s4_ctrl_reg;
    item_ctrl_t              s5_ctrl_reg;
    store_col_t              store_col;
    pix_col_t                new_col;
    pix_col_t                cell_col [KSIZE];
    logic [PSUM_W-1:0]       cell_psum [KSIZE];
    cell_ctrl_t              cell_ctrl [KSIZE];
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [2*SUM_W-1:0]      prod_reg;
    logic [2*SUM_W-1:0]      prod_next;
    out_item_t               res_item;

    // output queue credit
    logic [CNT_W-1:0]        fifo_count;
    logic [INF_W-1:0]        inflight;
    logic [USE_W-1:0]        used;

    // ---------------- configuration registers ----------------
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_wdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // drop the low two bits, then saturate into the supported range
    always_comb begin
        w_raw = EW'(width_reg) & ~EW'(3);
        if (w_raw < EW'(4)) begin
            w_sat = EW'(4);
        end else if (w_raw > EW'(MAXW4)) begin
            w_sat = EW'(MAXW4);
        end else begin
            w_sat = w_raw;
        end
        w_eff = WW'(w_sat);

        h_raw = height_reg & ~HEIGHT_REG_W'(3);
        if (h_raw < HEIGHT_REG_W'(4)) begin
            h_eff = HEIGHT_REG_W'(4);
        end else if (h_raw > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    // ---------------- position and request control ----------------
    assign inflight = INF_W'($countones({s1_ctrl_reg.emit, s2_ctrl_reg.emit,
                                         s3_ctrl_reg.emit, s4_ctrl_reg.emit,
                                         s5_ctrl_reg.emit}));
    assign used     = USE_W'(fifo_count) + USE_W'(inflight);
    assign s_ready  = aresetn && (used < USE_W'(OUT_FIFO_DEPTH));
    assign accept   = s_valid && s_ready;

    always_comb begin
        c0       = s_data.frame_start ? '0 : col_reg;
        r0       = s_data.frame_start ? '0 : row_reg;
        c_ext    = WW'(c0);
        c_inc    = WW'(c_ext + 1'b1);
        r_ext    = HEIGHT_REG_W'(r0);
        r_inc    = HEIGHT_REG_W'(r_ext + 1'b1);
        wrap_col = (c_inc >= w_eff);
        wrap_row = (r_inc >= h_eff);

        ctrl_in.emit      = (c0[1:0] == 2'd2) && (r0[1:0] == 2'd2)
                            && (c_ext < w_eff) && (r_ext < h_eff);
        ctrl_in.vclamp    = (r0 == ROW_W'(2));
        ctrl_in.hclamp    = (c0 == AW'(2));
        ctrl_in.row_end   = (c_ext == WW'(w_eff - WW'(2)));
        ctrl_in.frame_end = ctrl_in.row_end && (r_ext == HEIGHT_REG_W'(h_eff - HEIGHT_REG_W'(2)));

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (wrap_col) begin
                col_next = '0;
                row_next = wrap_row ? '0 : ROW_W'(r_inc);
            end else begin
                col_next = AW'(c_inc);
                row_next = r0;
            end
        end

        s1_ctrl_next = accept ? ctrl_in : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            s1_acc_reg  <= 1'b0;
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
            s5_ctrl_reg <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            s1_acc_reg  <= accept;
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
            s4_ctrl_reg <= s3_ctrl_reg;
            s5_ctrl_reg <= s4_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pix_reg <= s_data.pixel;
    end

    // ---------------- row store ----------------
    g5ds_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk    (aclk),
        .wr_en   (accept),
        .slot    (r0[SLOT_W-1:0]),
        .addr    (c0),
        .wr_data (s_data.pixel),
        .rd_col  (store_col)
    );

    always_comb begin
        for (int i = 0; i < STORE_ROWS; i++) begin
            new_col[i] = store_col[i];
        end
        new_col[KSIZE-1] = s1_pix_reg;
    end

    // ---------------- window: chain of column cells ----------------
    for (genvar j = 0; j < KSIZE; j++) begin : g_cell
        pix_col_t cin;

        assign cell_ctrl[j].shift   = s1_acc_reg;
        assign cell_ctrl[j].use_alt = (j < 2) && s2_ctrl_reg.hclamp;
        assign cell_ctrl[j].vclamp  = s2_ctrl_reg.vclamp;

        if (j == KSIZE - 1) begin : g_head
            assign cin = new_col;
        end else begin : g_link
            assign cin = cell_col[j+1];
        end

        g5ds_cell #(
            .COL (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl[j]),
            .col_in  (cin),
            .alt_col (cell_col[2]),
            .col_out (cell_col[j]),
            .psum    (cell_psum[j])
        );
    end

    // ---------------- sum and divide by 159 ----------------
    always_comb begin
        sum_next = '0;
        for (int j = 0; j < KSIZE; j++) begin
            sum_next = sum_next + SUM_W'(cell_psum[j]);
        end
        prod_next = (2*SUM_W)'(sum_reg) * (2*SUM_W)'(RECIP_MUL);
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
    end

    assign res_item.filtered  = prod_reg[RECIP_SHIFT +: PIX_W];
    assign res_item.row_end   = s5_ctrl_reg.row_end;
    assign res_item.frame_end = s5_ctrl_reg.frame_end;

    g5ds_ofifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_ofifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s5_ctrl_reg.emit),
        .wr_data  (res_item),
        .rd_ready (m_ready),
        .rd_valid (m_valid),
        .rd_data  (m_data),
        .count    (fifo_count)
    );

    // ---------------- assertions ----------------
    a_credit : assert property (@(posedge aclk) disable iff (!aresetn)
        used <= USE_W'(OUT_FIFO_DEPTH))
        else $error("output queue credit exceeded");

    a_frame_start_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.frame_start |=> (col_reg == AW'(1)) && (row_reg == '0))
        else $error("frame start did not restart the position");

    a_frame_end_row : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.row_end)
        else $error("frame end without row end");

endmodule

FILE: rtl/g5ds_cell.sv
// ----------------------------------------------------------------------------
// g5ds_cell
// One window column: holds five pixels, takes its neighbor's column on a
// shift and forms the column's weighted partial sum.
// ----------------------------------------------------------------------------
module g5ds_cell
    import g5ds_pkg::*;
#(
    parameter int COL = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  pix_col_t          col_in,
    input  pix_col_t          alt_col,
    output pix_col_t          col_out,
    output logic [PSUM_W-1:0] psum
);

    pix_col_t          col_reg;
    pix_col_t          col_next;
    pix_col_t          src;
    logic [PSUM_W-1:0] psum_reg;
    logic [PSUM_W-1:0] psum_next;

    always_comb begin
        col_next = ctrl.shift ? col_in : col_reg;
    end

    // left edge: borrow the center column; top edge: repeat row zero upward
    always_comb begin
        src = ctrl.use_alt ? alt_col : col_reg;
        if (ctrl.vclamp) begin
            src[0] = src[2];
            src[1] = src[2];
        end
        psum_next = '0;
        for (int i = 0; i < KSIZE; i++) begin
            psum_next = psum_next + PSUM_W'(src[i]) * PSUM_W'(KERN[i][COL]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

FILE: rtl/g5ds_linebuf.sv
// ----------------------------------------------------------------------------
// g5ds_linebuf
// Four row-store banks, one per row slot. All banks are read at the
// current column every cycle; the slot of the oldest row is overwritten.
// ----------------------------------------------------------------------------
module g5ds_linebuf
    import g5ds_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] slot,
    input  logic [AW-1:0]     addr,
    input  pix_t              wr_data,
    output store_col_t        rd_col
);

    pix_t              bank_rd [STORE_ROWS];
    logic [SLOT_W-1:0] slot_reg;

    for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
        pix_t bank_mem [MAX_WIDTH];
        pix_t bank_rd_reg;

        // read returns the old word when the same address is written
        always_ff @(posedge aclk) begin
            bank_rd_reg <= bank_mem[addr];
            if (wr_en && slot == SLOT_W'(b)) begin
                bank_mem[addr] <= wr_data;
            end
        end

        assign bank_rd[b] = bank_rd_reg;
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot;
    end

    // order oldest row first
    always_comb begin
        for (int i = 0; i < STORE_ROWS; i++) begin
            rd_col[i] = bank_rd[SLOT_W'(slot_reg + SLOT_W'(i))];
        end
    end

endmodule

FILE: rtl/g5ds_ofifo.sv
// ----------------------------------------------------------------------------
// g5ds_ofifo
// Small result queue between the filter pipeline and the output channel.
// ----------------------------------------------------------------------------
module g5ds_ofifo
    import g5ds_pkg::*;
#(
    parameter  int DEPTH = OUT_FIFO_DEPTH,
    localparam int PW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  out_item_t        wr_data,
    input  logic             rd_ready,
    output logic             rd_valid,
    output out_item_t        rd_data,
    output logic [CNT_W-1:0] count
);

    out_item_t        buf_mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_rd;

    assign rd_valid = (count_reg != '0);
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !do_rd) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (!wr_en && do_rd) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = buf_mem[rd_ptr_reg];
    assign count   = count_reg;

endmodule

FILE: sim/gauss_5x5_downsample_by_four_top_tb.sv
// ----------------------------------------------------------------------------
// gauss_5x5_downsample_by_four_top_tb
// Self-checking bench for the 5x5 Gaussian downsample-by-four block.
// ----------------------------------------------------------------------------
// A queue of pixel requests feeds a bursty driver; every accepted pixel runs
// through a behavioral copy of the filter (row stores, 5x5 window, edge clamp,
// divide by 159), and each filtered output that leaves the block is matched
// against the oldest pending value. Frame sizes cover the register extremes,
// out-of-range writes, wrapping frames, restarts and mid-frame size changes,
// while the output side stalls on patterns of its own.
// ----------------------------------------------------------------------------
module gauss_5x5_downsample_by_four_top_tb;
    import g5ds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W        = MAX_WIDTH_DEF;
    localparam int unsigned MAX_ROWS     = MAX_HEIGHT;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned SETTLE       = 16;
    localparam int unsigned DRAIN_LIMIT  = 4000;

    localparam int unsigned GK [KSIZE][KSIZE] = '{
        '{2, 4,  5,  4,  2},
        '{4, 9,  12, 9,  4},
        '{5, 12, 15, 12, 5},
        '{4, 9,  12, 9,  4},
        '{2, 4,  5,  4,  2}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // behavioral filter state
    pix_t                     line_mem [STORE_ROWS*MAX_W] = '{default: '0};
    pix_t                     win [KSIZE][KSIZE]          = '{default: '0};
    int unsigned              col_pos    = 0;
    int unsigned              row_pos    = 0;
    logic [WIDTH_REG_W-1:0]   width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0]  height_reg = HEIGHT_RESET;

    in_item_t    pixel_q [$];
    out_item_t   filtered_q [$];

    int unsigned n_queued       = 0;
    int unsigned n_pixels       = 0;
    int unsigned n_filtered     = 0;
    int unsigned n_cfg_writes   = 0;
    int unsigned n_drain_pauses = 0;
    int unsigned n_fail         = 0;

    gauss_5x5_downsample_by_four_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4ns aclk = ~aclk;

    function automatic int unsigned clamp_size(int unsigned raw, int unsigned top);
        int unsigned s;
        int unsigned lim;
        lim = top & ~32'd3;
        s = raw & ~32'd3;
        if (s < 4) s = 4;
        if (s > lim) s = lim;
        return s;
    endfunction

    // Advance the filter by one pixel and queue the output it produces, if any.
    task automatic filter_step(in_item_t it);
        int unsigned w, h, c, r, slot, ii, jj, sum, i, j;
        pix_t        colv [KSIZE];
        out_item_t   o;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_ROWS);
        if (it.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        for (i = 0; i < STORE_ROWS; i++) begin
            slot = (r + i) & 3;
            colv[i] = (c < MAX_W) ? line_mem[slot*MAX_W + c] : '0;
        end
        colv[KSIZE-1] = it.pixel;
        if (c < MAX_W) line_mem[(r & 3)*MAX_W + c] = it.pixel;
        for (i = 0; i < KSIZE; i++) begin
            for (j = 0; j < KSIZE-1; j++) win[i][j] = win[i][j+1];
            win[i][KSIZE-1] = colv[i];
        end
        if ((c & 3) == 2 && (r & 3) == 2 && c < w && r < h) begin
            sum = 0;
            for (i = 0; i < KSIZE; i++) begin
                // rows and columns above or left of the frame repeat index zero
                ii = (r == 2 && i < 2) ? 2 : i;
                for (j = 0; j < KSIZE; j++) begin
                    jj = (c == 2 && j < 2) ? 2 : j;
                    sum += win[ii][jj] * GK[i][j];
                end
            end
            o.filtered  = 16'(sum / 159);
            o.row_end   = (c == w - 2);
            o.frame_end = (c == w - 2) && (r == h - 2);
            filtered_q.push_back(o);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Driver: bursts of requests with random gaps, plus an occasional full drain.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    bit          hold_drain = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_step(s_data);
                n_pixels++;
            end
            if (!s_valid || s_ready) begin
                if (hold_drain && filtered_q.size() == 0) hold_drain = 1'b0;
                if (hold_drain || gap_left > 0 || pixel_q.size() == 0) begin
                    if (!hold_drain && gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= pixel_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                        if ((n_pixels > 200 && n_drain_pauses == 0) ||
                            $urandom_range(0, 39) == 0) begin
                            hold_drain = 1'b1;
                            n_drain_pauses++;
                        end
                    end
                end
            end
        end
    end

    // Monitor: stall the output on a changing pattern and check every output.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned stall_tick = 0;

    always @(posedge aclk) begin
        out_item_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected output: filtered %0d row_end %0b frame_end %0b",
                           m_data.filtered, m_data.row_end, m_data.frame_end);
                    n_fail++;
                end else begin
                    due = filtered_q.pop_front();
                    n_filtered++;
                    if (m_data.filtered !== due.filtered) begin
                        $error("filtered: expected %0d, got %0d", due.filtered, m_data.filtered);
                        n_fail++;
                    end
                    if (m_data.row_end !== due.row_end) begin
                        $error("row_end: expected %0b, got %0b", due.row_end, m_data.row_end);
                        n_fail++;
                    end
                    if (m_data.frame_end !== due.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               due.frame_end, m_data.frame_end);
                        n_fail++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            stall_tick++;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= (stall_tick % 5 == 0);
                default: m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
        else                        height_reg = val[HEIGHT_REG_W-1:0];
        n_cfg_writes++;
    endtask

    // Queue n pixels; fill < 0 gives random values weighted toward the extremes.
    task automatic queue_pixels(int unsigned n, bit starts, int unsigned start_odds, int fill);
        in_item_t    it;
        int unsigned k;
        for (k = 0; k < n; k++) begin
            if (fill >= 0) begin
                it.pixel = 16'(fill);
            end else begin
                case ($urandom_range(0, 15))
                    0:       it.pixel = '0;
                    1:       it.pixel = '1;
                    default: it.pixel = 16'($urandom);
                endcase
            end
            if (k == 0) it.frame_start = starts;
            else        it.frame_start = (start_odds > 0) &&
                                         ($urandom_range(1, start_odds) == 1);
            pixel_q.push_back(it);
        end
        n_queued += n;
    endtask

    // Wait until every request is taken and every output has come, then settle.
    task automatic drain_all();
        int unsigned waited;
        // sample between edges so the driver has settled
        do @(negedge aclk); while (pixel_q.size() != 0 || s_valid);
        waited = 0;
        while (filtered_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (filtered_q.size() != 0) begin
            $error("%0d filtered outputs never arrived", filtered_q.size());
            n_fail++;
            filtered_q.delete();
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int unsigned random_base, w, h, raw, frames, k;
        bit          resume;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 4x4 frames from out-of-range writes, full-scale window,
        // a wrap into the next frame without a start marker, a mid-frame restart.
        cfg_write(REG_IMAGE_WIDTH, 15'h6005);
        cfg_write(REG_IMAGE_HEIGHT, 15'd3);
        queue_pixels(16, 1'b1, 0, 16'hFFFF);
        queue_pixels(11, 1'b0, 0, 0);
        queue_pixels(5, 1'b1, 0, -1);
        drain_all();

        // Widest setting: part of the first row, where no output may appear.
        cfg_write(REG_IMAGE_WIDTH, 15'h1FFF);
        cfg_write(REG_IMAGE_HEIGHT, 15'd0);
        queue_pixels(200, 1'b1, 0, -1);
        drain_all();

        // Tallest setting at the narrowest width: the first rows of the frame.
        cfg_write(REG_IMAGE_WIDTH, 15'd2);
        cfg_write(REG_IMAGE_HEIGHT, 15'h7FFF);
        queue_pixels(4 * 24, 1'b1, 0, -1);
        drain_all();

        // Write the first 32 columns of every row slot before any size change
        // in the middle of a frame; no later frame is wider than that.
        cfg_write(REG_IMAGE_WIDTH, 15'd32);
        cfg_write(REG_IMAGE_HEIGHT, 15'd4);
        queue_pixels(32 * 4, 1'b1, 0, -1);
        drain_all();

        // Size changes in the middle of a frame: shrink past the column,
        // shrink past the row, then grow again.
        cfg_write(REG_IMAGE_WIDTH, 15'd18);
        cfg_write(REG_IMAGE_HEIGHT, 15'd8);
        queue_pixels(44, 1'b1, 0, -1);
        drain_all();
        cfg_write(REG_IMAGE_WIDTH, 15'd8);
        queue_pixels(30, 1'b0, 0, -1);
        drain_all();
        cfg_write(REG_IMAGE_HEIGHT, 15'd5);
        queue_pixels(40, 1'b0, 0, -1);
        drain_all();
        cfg_write(REG_IMAGE_WIDTH, 15'd24);
        queue_pixels(150, 1'b0, 0, -1);
        drain_all();

        random_base = n_queued;
        while (n_queued - random_base < RANDOM_ITEMS) begin
            resume = 1'b0;
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 5))
                    0:       raw = $urandom_range(0, 7);
                    1:       raw = 4 * $urandom_range(1, 2);
                    default: raw = 4 * $urandom_range(1, 8);
                endcase
                raw = raw | $urandom_range(0, 3) | ($urandom_range(0, 3) << WIDTH_REG_W);
                cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(raw));
                if ($urandom_range(0, 1) == 0) begin
                    raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                      : 4 * $urandom_range(1, 4);
                    raw = raw | $urandom_range(0, 3);
                    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(raw));
                end
                // sometimes carry on from wherever the last frame stopped
                resume = ($urandom_range(0, 3) == 0);
            end
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_ROWS);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    frames = $urandom_range(1, 3);
                    for (k = 0; k < frames; k++)
                        queue_pixels(w * h, (k == 0) ? !resume : 1'($urandom_range(0, 1)),
                                     0, -1);
                end
                6, 7: begin
                    queue_pixels($urandom_range(1, w * h - 1), !resume, 0, -1);
                    queue_pixels(w * h, 1'b1, 0, -1);
                end
                default: begin
                    queue_pixels($urandom_range(1, 2 * w * h), 1'($urandom_range(0, 1)),
                                 $urandom_range(3, 40), -1);
                end
            endcase
            drain_all();
        end

        drain_all();
        repeat (2 * SETTLE) @(posedge aclk);
        $display("Run covered %0d pixels and %0d filtered outputs over %0d register writes,",
                 n_pixels, n_filtered, n_cfg_writes);
        $display("frames from 4x4 up to partial ones at 4096 wide and 16384 tall, %0d drains.",
                 n_drain_pauses);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout: %0d pixels taken, %0d outputs outstanding", n_pixels,
                 filtered_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/g5ds_pkg.sv
rtl/g5ds_cell.sv
rtl/g5ds_linebuf.sv
rtl/g5ds_ofifo.sv
rtl/gauss_5x5_downsample_by_four_top.sv
sim/gauss_5x5_downsample_by_four_top_tb.sv
